FILE: hdl/roc_pkg.sv
`default_nettype none

package roc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int IDENT_WIDTH = 16;
   localparam int COUNT_WIDTH = 7;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic                          valid;
      logic signed [COORD_WIDTH-1:0] left;
      logic signed [COORD_WIDTH-1:0] bottom;
      logic signed [COORD_WIDTH-1:0] right;
      logic signed [COORD_WIDTH-1:0] top;
      logic [IDENT_WIDTH-1:0]        ident;
      logic                          first;
      logic [COUNT_WIDTH-1:0]        count;
      logic                          found;
      logic [IDENT_WIDTH-1:0]        hit_id;
   } roc_query_type;

endpackage

`default_nettype wire

FILE: hdl/roc_cell.sv
`default_nettype none

module roc_cell
   import roc_pkg::*;
#(
   parameter int CELL_INDEX  = 0,
   parameter int SLOT_WIDTH  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire roc_query_type         q_in,
   input  wire logic [SLOT_WIDTH-1:0] slot_in,
   output roc_query_type              q_out,
   output logic [SLOT_WIDTH-1:0]      slot_out
);

   localparam logic [SLOT_WIDTH-1:0] MY_SLOT = SLOT_WIDTH'(CELL_INDEX);

   logic signed [COORD_WIDTH-1:0] left_ff;
   logic signed [COORD_WIDTH-1:0] bottom_ff;
   logic signed [COORD_WIDTH-1:0] right_ff;
   logic signed [COORD_WIDTH-1:0] top_ff;
   logic [IDENT_WIDTH-1:0]        ident_ff;

   roc_query_type         q_ff;
   roc_query_type         q_next_in;
   logic [SLOT_WIDTH-1:0] slot_ff;
   logic                  occupied;
   logic                  hit;

   always_comb begin
      occupied = (MY_SLOT < slot_in);
      hit = occupied
         && ($signed(q_in.left) < right_ff) && (left_ff < $signed(q_in.right))
         && ($signed(q_in.bottom) < top_ff) && (bottom_ff < $signed(q_in.top));
      q_next_in = q_in;
      if (hit) begin
         if (!q_in.found) begin
            q_next_in.hit_id = ident_ff;
         end
         q_next_in.found = 1'b1;
         if (q_in.count != COUNT_MAX) begin
            q_next_in.count = q_in.count + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && q_in.valid && (slot_in == MY_SLOT)) begin
         left_ff   <= q_in.left;
         bottom_ff <= q_in.bottom;
         right_ff  <= q_in.right;
         top_ff    <= q_in.top;
         ident_ff  <= q_in.ident;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (advance) begin
         q_ff    <= q_next_in;
         slot_ff <= slot_in;
      end
   end

   assign q_out    = q_ff;
   assign slot_out = slot_ff;

endmodule

`default_nettype wire

FILE: hdl/rectangle_overlap_checker_unit.sv
`default_nettype none
// Rectangle overlap checker.
// A rectangle beat on the req_ channel carries its lower-left corner, width,
// height, identifier and a first_of_set flag that starts a new set. Each
// rectangle is checked for strict overlap against every rectangle stored in
// the current set and then stored if fewer than MAX_RECTS are held.
// One rsp_ beat is returned per rectangle, in order, with the overlap count,
// the id of the earliest overlapping rectangle and the running set status.
// The design is a chain of MAX_RECTS cells behind one entry register. Each
// cell holds one stored rectangle and compares it with the query passing by.
// Each query passes through the entry register and then every cell before
// rsp_valid; a new rectangle can be accepted in every cycle while results are taken.
// When the receiver stalls, the whole chain holds and req_ready drops in the
// same cycle; nothing is lost.
// Reset empties the chain and the store count and marks the set as clear.
// Stored contents are not cleared; entries beyond the count are never compared.
module rectangle_overlap_checker_unit
   import roc_pkg::*;
#(
   parameter int MAX_RECTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [30:0] req_left_x,
   input  wire logic [30:0] req_bottom_y,
   input  wire logic [29:0] req_rect_width,
   input  wire logic [29:0] req_rect_height,
   input  wire logic [15:0] req_rect_id,
   input  wire logic        req_first_of_set,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_overlap_count,
   output logic             rsp_overlap_found,
   output logic [15:0]      rsp_first_hit_id,
   output logic             rsp_set_clear,
   output logic             rsp_store_full
);

   localparam int SLOT_WIDTH = $clog2(MAX_RECTS + 1);
   localparam logic [SLOT_WIDTH-1:0] SLOT_FULL = SLOT_WIDTH'(MAX_RECTS);

   logic                  advance;
   logic [SLOT_WIDTH-1:0] count_ff;
   logic [SLOT_WIDTH-1:0] count_in;
   logic [SLOT_WIDTH-1:0] entry_slot;
   logic                  clear_ff;
   logic                  accept;
   roc_query_type         entry_in;
   roc_query_type         entry_ff;
   logic [SLOT_WIDTH-1:0] entry_slot_ff;

   roc_query_type         q_chain    [0:MAX_RECTS];
   logic [SLOT_WIDTH-1:0] slot_chain [0:MAX_RECTS];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_comb begin
      entry_slot = req_first_of_set ? '0 : count_ff;
      count_in   = (entry_slot == SLOT_FULL) ? entry_slot
                                             : entry_slot + SLOT_WIDTH'(1);
      entry_in.valid  = req_valid;
      entry_in.left   = {req_left_x[30], req_left_x};
      entry_in.bottom = {req_bottom_y[30], req_bottom_y};
      entry_in.right  = {req_left_x[30], req_left_x} + $signed({2'b00, req_rect_width});
      entry_in.top    = {req_bottom_y[30], req_bottom_y} + $signed({2'b00, req_rect_height});
      entry_in.ident  = req_rect_id;
      entry_in.first  = req_first_of_set;
      entry_in.count  = '0;
      entry_in.found  = 1'b0;
      entry_in.hit_id = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         entry_ff.valid <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (advance) begin
            entry_ff      <= entry_in;
            entry_slot_ff <= entry_slot;
         end
      end
   end

   assign q_chain[0]    = entry_ff;
   assign slot_chain[0] = entry_slot_ff;

   for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
      roc_cell #(
         .CELL_INDEX (i),
         .SLOT_WIDTH (SLOT_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .q_in     (q_chain[i]),
         .slot_in  (slot_chain[i]),
         .q_out    (q_chain[i+1]),
         .slot_out (slot_chain[i+1])
      );
   end

   assign rsp_valid         = q_chain[MAX_RECTS].valid;
   assign rsp_overlap_count = q_chain[MAX_RECTS].count;
   assign rsp_overlap_found = q_chain[MAX_RECTS].found;
   assign rsp_first_hit_id  = q_chain[MAX_RECTS].hit_id;
   assign rsp_store_full    = (slot_chain[MAX_RECTS] == SLOT_FULL);
   assign rsp_set_clear     = (q_chain[MAX_RECTS].first || clear_ff)
                              && !q_chain[MAX_RECTS].found;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         clear_ff <= rsp_set_clear;
      end
   end

   a_found_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_overlap_found == (rsp_overlap_count != '0)))
      else $error("overlap flag disagrees with overlap count");

   a_no_hit_id_without_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_overlap_found) |-> (rsp_first_hit_id == '0))
      else $error("hit id reported without an overlap");

   a_overlap_ends_clear_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_overlap_found) |=> !clear_ff)
      else $error("set still marked clear after an overlap");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      accept |=> (count_ff <= SLOT_FULL))
      else $error("store count beyond capacity");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import roc_pkg::*;

   localparam int MAX_RECTS = 64;
   localparam int TARGET_RECTS = 1160;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [30:0] left_x;
      logic signed [30:0] bottom_y;
      logic [29:0]        width;
      logic [29:0]        height;
      logic [15:0]        id;
      logic               first;
      int unsigned        gap;
      bit                 drain;
   } rect_item_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic                   found;
      logic [IDENT_WIDTH-1:0] hit_id;
      logic                   set_clear;
      logic                   store_full;
   } overlap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [30:0] req_left_x = '0;
   logic [30:0] req_bottom_y = '0;
   logic [29:0] req_rect_width = '0;
   logic [29:0] req_rect_height = '0;
   logic [15:0] req_rect_id = '0;
   logic        req_first_of_set = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_overlap_count;
   logic        rsp_overlap_found;
   logic [15:0] rsp_first_hit_id;
   logic        rsp_set_clear;
   logic        rsp_store_full;

   rectangle_overlap_checker_unit #(
      .MAX_RECTS(MAX_RECTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_left_x(req_left_x),
      .req_bottom_y(req_bottom_y),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_rect_id(req_rect_id),
      .req_first_of_set(req_first_of_set),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_overlap_count(rsp_overlap_count),
      .rsp_overlap_found(rsp_overlap_found),
      .rsp_first_hit_id(rsp_first_hit_id),
      .rsp_set_clear(rsp_set_clear),
      .rsp_store_full(rsp_store_full)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rect_item_type      rect_queue[$];
   overlap_result_type pending_results[$];

   logic signed [COORD_WIDTH-1:0] st_left   [MAX_RECTS];
   logic signed [COORD_WIDTH-1:0] st_bottom [MAX_RECTS];
   logic signed [COORD_WIDTH-1:0] st_right  [MAX_RECTS];
   logic signed [COORD_WIDTH-1:0] st_top    [MAX_RECTS];
   logic [IDENT_WIDTH-1:0]        st_ident  [MAX_RECTS];
   int                            stored_total = 0;
   logic                          set_is_clear = 1'b1;

   int  rects_total = 0;
   int  rects_sent = 0;
   int  sets_started = 0;
   int  results_seen = 0;
   int  overlaps_seen = 0;
   int  full_seen = 0;
   int  error_count = 0;
   bit  quiet_gaps = 1'b0;
   bit  drain_next = 1'b0;

   function automatic overlap_result_type check_against_store(input rect_item_type r);
      overlap_result_type            res;
      logic signed [COORD_WIDTH-1:0] l, b, rt, tp;
      int                            i;
      l = {r.left_x[30], r.left_x};
      b = {r.bottom_y[30], r.bottom_y};
      rt = l + $signed({2'b00, r.width});
      tp = b + $signed({2'b00, r.height});
      res = '0;
      if (r.first) begin
         stored_total = 0;
         set_is_clear = 1'b1;
      end
      for (i = 0; i < stored_total; i++) begin
         if (l < st_right[i] && st_left[i] < rt && b < st_top[i] && st_bottom[i] < tp) begin
            if (!res.found) begin
               res.hit_id = st_ident[i];
            end
            res.found = 1'b1;
            if (res.count != COUNT_MAX) begin
               res.count = res.count + 1'b1;
            end
         end
      end
      if (res.found) begin
         set_is_clear = 1'b0;
      end
      res.set_clear = set_is_clear;
      res.store_full = (stored_total >= MAX_RECTS);
      if (!res.store_full) begin
         st_left[stored_total] = l;
         st_bottom[stored_total] = b;
         st_right[stored_total] = rt;
         st_top[stored_total] = tp;
         st_ident[stored_total] = r.id;
         stored_total++;
      end
      return res;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic add_rect(input int l, input int b, input int w, input int h,
                           input int id, input bit first);
      rect_item_type item;
      item.left_x = 31'(l);
      item.bottom_y = 31'(b);
      item.width = 30'(w);
      item.height = 30'(h);
      item.id = 16'(id);
      item.first = first;
      item.gap = quiet_gaps ? 0 : $urandom_range(0, 6);
      item.drain = drain_next;
      drain_next = 1'b0;
      if (first) begin
         sets_started++;
      end
      rect_queue.push_back(item);
   endtask

   // Driver: presents queued rectangles and predicts each one as it is accepted.
   rect_item_type in_flight;
   int unsigned   idle_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_results.push_back(check_against_store(in_flight));
            rects_sent++;
         end
         if (!req_valid || req_ready) begin
            if (rect_queue.size() != 0 && idle_cycles >= rect_queue[0].gap &&
                !(rect_queue[0].drain && pending_results.size() != 0)) begin
               in_flight = rect_queue.pop_front();
               req_left_x <= in_flight.left_x;
               req_bottom_y <= in_flight.bottom_y;
               req_rect_width <= in_flight.width;
               req_rect_height <= in_flight.height;
               req_rect_id <= in_flight.id;
               req_first_of_set <= in_flight.first;
               req_valid <= 1'b1;
               idle_cycles = 0;
            end else begin
               req_valid <= 1'b0;
               idle_cycles++;
            end
         end
      end
   end

   // Monitor: checks every result beat against the oldest prediction.
   overlap_result_type got, want;
   int unsigned        stall_left = 0;
   bit                 rsp_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.count = rsp_overlap_count;
            got.found = rsp_overlap_found;
            got.hit_id = rsp_first_hit_id;
            got.set_clear = rsp_set_clear;
            got.store_full = rsp_store_full;
            results_seen++;
            if (got.found === 1'b1) begin
               overlaps_seen++;
            end
            if (got.store_full === 1'b1) begin
               full_seen++;
            end
            if (pending_results.size() == 0) begin
               note_failure($sformatf("result beat with nothing expected: count=%0d found=%b",
                                      got.count, got.found));
            end else begin
               want = pending_results.pop_front();
               if (got.count !== want.count || got.found !== want.found ||
                   got.hit_id !== want.hit_id || got.set_clear !== want.set_clear ||
                   got.store_full !== want.store_full) begin
                  note_failure($sformatf({"result %0d: expected count=%0d found=%b hit=%h ",
                                          "clear=%b full=%b, got count=%0d found=%b hit=%h ",
                                          "clear=%b full=%b"},
                                         results_seen, want.count, want.found, want.hit_id,
                                         want.set_clear, want.store_full, got.count,
                                         got.found, got.hit_id, got.set_clear,
                                         got.store_full));
               end
            end
            if ($urandom_range(0, 39) == 0) begin
               rsp_calm = !rsp_calm;
            end
            stall_left = rsp_calm ? 0 : $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int set_len, mode, span, base_x, base_y, k;

      // Extreme corners and full extents.
      add_rect(-1073741824, -1073741824, 1073741823, 1073741823, 16'hFFFF, 1'b1);
      add_rect(1073741823, 1073741823, 1073741823, 1073741823, 0, 1'b0);
      // Overlap with an id of zero, with corner sums past the coordinate range.
      add_rect(1073741813, 1073741813, 20, 20, 16'h00AA, 1'b0);
      // Degenerate rectangles still overlap when they lie strictly inside another.
      add_rect(-100, -100, 0, 10, 16'h0010, 1'b0);
      add_rect(-100, -100, 10, 0, 16'h0011, 1'b0);
      add_rect(0, 0, 10, 10, 1, 1'b0);
      add_rect(3, 3, 0, 0, 16'h0012, 1'b0);
      // Touching edges do not count.
      add_rect(10, 0, 10, 10, 2, 1'b0);
      add_rect(0, 10, 10, 10, 3, 1'b0);
      add_rect(-10, -10, 10, 10, 16'h0013, 1'b0);
      add_rect(0, 0, 10, 10, 4, 1'b0);
      add_rect(2, 2, 2, 2, 5, 1'b0);
      add_rect(-5, -5, 100, 100, 6, 1'b0);
      // A cross where neither lower-left corner lies inside the other.
      add_rect(1, -5, 8, 20, 7, 1'b0);
      add_rect(-5, 1, 20, 8, 8, 1'b0);
      drain_next = 1'b1;
      add_rect(0, 0, 10, 10, 9, 1'b1);
      add_rect(5, 5, 10, 10, 10, 1'b0);
      add_rect(-1, -1, 2, 2, 16'hFFFF, 1'b0);
      add_rect(-1073741824, 0, 1073741823, 1, 16'h5555, 1'b1);
      add_rect(-2, 0, 1073741823, 1, 16'hAAAA, 1'b0);

      while (rect_queue.size() < TARGET_RECTS) begin
         set_len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 24);
         mode = $urandom_range(0, 3);
         case ($urandom_range(0, 2))
            0: span = 16;
            1: span = 512;
            default: span = 1 << 20;
         endcase
         base_x = $urandom;
         base_y = $urandom;
         quiet_gaps = ($urandom_range(0, 3) == 0);
         drain_next = ($urandom_range(0, 7) == 0);
         for (k = 0; k < set_len; k++) begin
            if (mode == 0) begin
               add_rect($urandom, $urandom, $urandom, $urandom, $urandom,
                        k == 0 || $urandom_range(0, 29) == 0);
            end else begin
               add_rect(base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
                        $urandom_range(0, span), $urandom_range(0, span), $urandom,
                        k == 0 || $urandom_range(0, 29) == 0);
            end
         end
      end
      rects_total = rect_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (rects_sent < rects_total) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (MAX_RECTS + 20) @(posedge clock);

      $display("Checked %0d rectangles in %0d sets against a %0d-entry store.",
               rects_sent, sets_started, MAX_RECTS);
      $display("%0d results reported overlaps, %0d found the store full, %0d errors.",
               overlaps_seen, full_seen, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d of %0d rectangles accepted.", rects_sent, rects_total);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
hdl/roc_pkg.sv
hdl/roc_cell.sv
hdl/rectangle_overlap_checker_unit.sv
tb/sv/tb.sv
